// File: rtl/core/svm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the voice mixer
// Mode codes, default sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package svm_pkg;
	localparam int MAX_VOICES_D   = 16;
	localparam int NUM_SOUNDS_D   = 16;
	localparam int SAMPLE_WORDS_D = 65536;
	localparam int PERIOD_MAX_D   = 1024;

	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_DEFINE  = 2'd1;
	localparam logic [1:0] MODE_TRIGGER = 2'd2;
	localparam logic [1:0] MODE_MIX     = 2'd3;

	localparam logic [10:0] PERIOD_RESET = 11'd64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_MAC,
		ST_ADV,
		ST_DONE
	} state_t;

	// per-cycle controls from the sequencer to the datapath
	typedef struct packed {
		logic clr;
		logic mac;
	} mac_ctl_t;
endpackage

// File: rtl/core/svm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_mac: shared multiply-accumulate and output saturation
// One gain times sample product per cycle, while mac is set, into a wide accumulator.
// ----------------------------------------------------------------------------
module svm_mac (
	input  logic               clk,
	input  svm_pkg::mac_ctl_t  ctl,
	input  logic        [15:0] gain,
	input  logic signed [15:0] smp,
	output logic signed [15:0] result
);
	logic signed [39:0] acc_q;
	logic signed [32:0] prod;
	logic signed [25:0] q;

	assign prod = $signed({1'b0, gain}) * smp;

	always_ff @(posedge clk) begin
		if (ctl.clr)
			acc_q <= '0;
		else if (ctl.mac)
			acc_q <= acc_q + 40'(prod);
	end

	// arithmetic shift is floor, matching the rounding toward minus infinity
	assign q = 26'(acc_q >>> 14);

	always_comb begin
		if (q > 26'sd32767)
			result = 16'sh7fff;
		else if (q < -26'sd32768)
			result = -16'sh8000;
		else
			result = q[15:0];
	end
endmodule

// File: rtl/core/sample_voice_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_voice_mixer: polyphonic sample playback mixer
// Sample memory, sound table and voice table with a one-voice-per-step mixer.
// ----------------------------------------------------------------------------
// Sequence: load, define and trigger words pass SCAN and DONE before the strobe.
// Mix words pass SCAN, READ and MAC per voice, then ADV per voice at period end, then DONE.
// A new word is taken only while idle; busy drops as the strobe cycle begins.
// The shared multiplier and the single sample memory port make voices mix one at a time.
// Reset clears voice flags, sound table and period count, and sets period size to 64.
// The strobe is one cycle wide; the receiver cannot stall.
module sample_voice_mixer #(
	parameter int MAX_VOICES   = svm_pkg::MAX_VOICES_D,
	parameter int NUM_SOUNDS   = svm_pkg::NUM_SOUNDS_D,
	parameter int SAMPLE_WORDS = svm_pkg::SAMPLE_WORDS_D,
	parameter int PERIOD_MAX   = svm_pkg::PERIOD_MAX_D
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic        [10:0] cfg_wdata,
	input  logic         [1:0] mode,
	input  logic         [3:0] sound_id,
	input  logic        [15:0] sample_addr,
	input  logic signed [15:0] sample_value,
	input  logic        [15:0] sound_length,
	input  logic        [15:0] volume,
	output logic               strobe,
	output logic signed [15:0] mix_sample,
	output logic               last_in_period,
	output logic               status,
	output logic         [4:0] active_voices
);
	localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int SW = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
	localparam int AW = $clog2(SAMPLE_WORDS);
	localparam int PW = $clog2(PERIOD_MAX + 1);
	localparam int CW = $clog2(MAX_VOICES + 1);

	svm_pkg::state_t state_q, state_d;
	svm_pkg::mac_ctl_t mctl;

	// input word capture
	logic [1:0]  mode_q;
	logic [3:0]  id_q;
	logic [15:0] addr_q, len_q, vol_q;
	logic [15:0] val_q;
	logic [10:0] psize_q;

	// sample memory, one port
	logic [15:0] mem [SAMPLE_WORDS];
	logic [15:0] rd_s1;

	// sound table and voice table
	logic [15:0] snd_start_q [NUM_SOUNDS];
	logic [15:0] snd_len_q   [NUM_SOUNDS];
	logic [MAX_VOICES-1:0] act_q, pend_q;
	logic [3:0]  vsnd_q  [MAX_VOICES];
	logic [15:0] vgain_q [MAX_VOICES];
	logic [16:0] voff_q  [MAX_VOICES];
	logic [9:0]  pcnt_q;

	logic [VW-1:0] vi_q;
	logic          hit_q, stat_q, last_q;
	logic [15:0]   gain_q;
	logic signed [15:0] mix;

	// effective period, clamped to 1..PERIOD_MAX
	logic [PW-1:0] period;
	always_comb begin
		if (psize_q == 11'd0)
			period = PW'(1);
		else if (32'(psize_q) > PERIOD_MAX)
			period = PW'(PERIOD_MAX);
		else
			period = PW'(psize_q);
	end

	// current voice lookups; a stored sound number is always in range
	logic [SW-1:0] vs;
	logic [16:0]   pos;
	logic [16:0]   noff;
	logic          last_w;
	assign vs     = SW'(vsnd_q[vi_q]);
	assign pos    = voff_q[vi_q] + 17'(pcnt_q);
	assign noff   = voff_q[vi_q] + 17'(period);
	assign last_w = (32'(pcnt_q) + 1) >= 32'(period);

	// lowest free slot for triggers
	logic [VW-1:0] free_i;
	logic          free_ok;
	always_comb begin
		free_i  = '0;
		free_ok = 1'b0;
		for (int v = MAX_VOICES - 1; v >= 0; v--) begin
			if (!act_q[v] && !pend_q[v]) begin
				free_i  = VW'(v);
				free_ok = 1'b1;
			end
		end
	end

	logic [CW-1:0] cnt;
	always_comb begin
		cnt = '0;
		for (int v = 0; v < MAX_VOICES; v++)
			cnt = cnt + CW'(act_q[v] | pend_q[v]);
	end

	logic vi_end;
	assign vi_end = (32'(vi_q) == MAX_VOICES - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			svm_pkg::ST_IDLE: if (start) state_d = svm_pkg::ST_SCAN;
			svm_pkg::ST_SCAN: state_d = (mode_q == svm_pkg::MODE_MIX) ?
				svm_pkg::ST_READ : svm_pkg::ST_DONE;
			svm_pkg::ST_READ: state_d = svm_pkg::ST_MAC;
			svm_pkg::ST_MAC: begin
				if (!vi_end)
					state_d = svm_pkg::ST_READ;
				else if (last_q)
					state_d = svm_pkg::ST_ADV;
				else
					state_d = svm_pkg::ST_DONE;
			end
			svm_pkg::ST_ADV: if (vi_end) state_d = svm_pkg::ST_DONE;
			svm_pkg::ST_DONE: state_d = svm_pkg::ST_IDLE;
			default: state_d = svm_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mctl.clr = 1'b0;
		mctl.mac = 1'b0;
		case (state_q)
			svm_pkg::ST_SCAN: mctl.clr = 1'b1;
			svm_pkg::ST_MAC:  mctl.mac = hit_q;
			default: ;
		endcase
	end

	assign busy = (state_q != svm_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svm_pkg::ST_IDLE;
			psize_q <= svm_pkg::PERIOD_RESET;
			act_q   <= '0;
			pend_q  <= '0;
			pcnt_q  <= '0;
			strobe  <= 1'b0;
			for (int s = 0; s < NUM_SOUNDS; s++) begin
				snd_start_q[s] <= '0;
				snd_len_q[s]   <= '0;
			end
		end else begin
			state_q <= state_d;
			strobe  <= (state_q == svm_pkg::ST_DONE);
			if (cfg_we)
				psize_q <= cfg_wdata;
			case (state_q)
				svm_pkg::ST_SCAN: begin
					if (mode_q == svm_pkg::MODE_DEFINE && 32'(id_q) < NUM_SOUNDS) begin
						snd_start_q[SW'(id_q)] <= addr_q;
						snd_len_q[SW'(id_q)]   <= len_q;
					end
					if (mode_q == svm_pkg::MODE_TRIGGER && 32'(id_q) < NUM_SOUNDS &&
							free_ok)
						pend_q[free_i] <= 1'b1;
					if (mode_q == svm_pkg::MODE_MIX && pcnt_q == 10'd0) begin
						act_q  <= act_q | pend_q;
						pend_q <= '0;
					end
				end
				svm_pkg::ST_MAC: if (vi_end) begin
					if (last_q)
						pcnt_q <= '0;
					else
						pcnt_q <= pcnt_q + 10'd1;
				end
				svm_pkg::ST_ADV: if (act_q[vi_q] && noff >= 17'(snd_len_q[vs]))
					act_q[vi_q] <= 1'b0;
				default: ;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_q <= mode;
			id_q   <= sound_id;
			addr_q <= sample_addr;
			val_q  <= sample_value;
			len_q  <= sound_length;
			vol_q  <= volume;
		end
		case (state_q)
			svm_pkg::ST_SCAN: begin
				vi_q   <= '0;
				stat_q <= 1'b0;
				last_q <= last_w;
				if (mode_q == svm_pkg::MODE_LOAD && 32'(addr_q) < SAMPLE_WORDS)
					mem[AW'(addr_q)] <= val_q;
				if (mode_q == svm_pkg::MODE_TRIGGER && 32'(id_q) < NUM_SOUNDS) begin
					if (free_ok) begin
						vsnd_q[free_i]  <= id_q;
						vgain_q[free_i] <= vol_q;
						voff_q[free_i]  <= '0;
					end else
						stat_q <= 1'b1;
				end
			end
			svm_pkg::ST_READ: begin
				rd_s1  <= mem[AW'(snd_start_q[vs] + pos[15:0])];
				hit_q  <= act_q[vi_q] && (pos < 17'(snd_len_q[vs]));
				gain_q <= vgain_q[vi_q];
			end
			svm_pkg::ST_MAC: if (!vi_end) vi_q <= vi_q + VW'(1); else vi_q <= '0;
			svm_pkg::ST_ADV: begin
				if (act_q[vi_q])
					voff_q[vi_q] <= noff;
				vi_q <= vi_q + VW'(1);
			end
			svm_pkg::ST_DONE: begin
				mix_sample     <= (mode_q == svm_pkg::MODE_MIX) ? mix : '0;
				last_in_period <= (mode_q == svm_pkg::MODE_MIX) && last_q;
				status         <= stat_q;
				active_voices  <= 5'(cnt);
			end
			default: ;
		endcase
	end

	svm_mac u_mac (
		.clk    (clk),
		.ctl    (mctl),
		.gain   (gain_q),
		.smp    ($signed(rd_s1)),
		.result (mix)
	);

	a_busy_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == svm_pkg::ST_DONE))
		else $error("strobe without done");
	a_no_pend_act: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q & pend_q) == '0)
		else $error("voice both active and pending");
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("busy during strobe");
endmodule
